// File: hdl/lsc_pkg.sv
// ----------------------------------------------------------------------------
// lsc_pkg: shared definitions for the line sensor calibration block
// Field widths, reset values, command and result codes, state encoding.
// ----------------------------------------------------------------------------
package lsc_pkg;

    localparam int MAX_SENSORS        = 8;
    localparam int SAMPLE_W           = 10;
    localparam int TICK_W             = 16;
    localparam int VALUE_W            = 13;
    localparam int IDX_W              = 3;
    localparam int SAMPLE_MAX         = 1023;
    localparam int DEF_SENSORS        = 8;
    localparam int DEF_POSITION_SCALE = 1000;
    localparam int IN_DATA_W          = 112;
    localparam int OUT_DATA_W         = 40;

    localparam logic [TICK_W-1:0] LIMIT_RESET = 16'd1000;

    typedef enum logic {
        CMD_POSITION  = 1'b0,
        CMD_CALIBRATE = 1'b1
    } lsc_cmd_t;

    typedef enum logic {
        KIND_POSITION  = 1'b0,
        KIND_THRESHOLD = 1'b1
    } lsc_kind_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DECODE,
        ST_SUM,
        ST_START,
        ST_DIV,
        ST_THRESH
    } lsc_state_t;

    // per-sensor calibration view of one lane
    typedef struct packed {
        logic [SAMPLE_W-1:0] low;
        logic [SAMPLE_W-1:0] high;
        logic [SAMPLE_W-1:0] threshold;
    } lsc_cal_t;

    // divider status seen by the controller
    typedef struct packed {
        logic busy;
        logic zero_divisor;
    } lsc_div_status_t;

endpackage

// File: hdl/lsc_lane.sv
// ----------------------------------------------------------------------------
// lsc_lane: one sensor lane
// Running min/max store, midpoint threshold and registered weighted term.
// ----------------------------------------------------------------------------
module lsc_lane #(
    parameter int WEIGHT  = 0,
    parameter int WTERM_W = 23
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic [lsc_pkg::SAMPLE_W-1:0]  sample,
    input  logic                          update,
    output lsc_pkg::lsc_cal_t             cal,
    output logic [WTERM_W-1:0]            weighted
);

    logic [lsc_pkg::SAMPLE_W-1:0] low_reg, low_next;
    logic [lsc_pkg::SAMPLE_W-1:0] high_reg, high_next;
    logic [WTERM_W-1:0]           weighted_reg;
    logic [lsc_pkg::SAMPLE_W:0]   mid_sum;

    always_comb begin
        low_next  = low_reg;
        high_next = high_reg;
        if (update) begin
            if (sample < low_reg) begin
                low_next = sample;
            end
            if (sample > high_reg) begin
                high_next = sample;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            low_reg  <= lsc_pkg::SAMPLE_W'(lsc_pkg::SAMPLE_MAX);
            high_reg <= '0;
        end else begin
            low_reg  <= low_next;
            high_reg <= high_next;
        end
    end

    // product against this lane's constant position weight
    always_ff @(posedge aclk) begin
        weighted_reg <= WTERM_W'(sample * WEIGHT);
    end

    assign mid_sum       = {1'b0, low_reg} + {1'b0, high_reg};
    assign cal.low       = low_reg;
    assign cal.high      = high_reg;
    assign cal.threshold = mid_sum[lsc_pkg::SAMPLE_W:1];
    assign weighted      = weighted_reg;

endmodule

// File: hdl/lsc_merge.sv
// ----------------------------------------------------------------------------
// lsc_merge: lane merge
// Registered sums of the weighted terms and of the raw samples.
// ----------------------------------------------------------------------------
module lsc_merge #(
    parameter int WTERM_W = 23,
    parameter int WSUM_W  = 25,
    parameter int SUM_W   = 13
) (
    input  logic                                                   aclk,
    input  logic [lsc_pkg::MAX_SENSORS-1:0][WTERM_W-1:0]           weighted,
    input  logic [lsc_pkg::MAX_SENSORS-1:0][lsc_pkg::SAMPLE_W-1:0] samples,
    output logic [WSUM_W-1:0]                                      wsum,
    output logic [SUM_W-1:0]                                       sum
);

    logic [WSUM_W-1:0] wsum_reg, wsum_next;
    logic [SUM_W-1:0]  sum_reg, sum_next;

    always_comb begin
        wsum_next = '0;
        sum_next  = '0;
        for (int i = 0; i < lsc_pkg::MAX_SENSORS; i++) begin
            wsum_next = wsum_next + WSUM_W'(weighted[i]);
            sum_next  = sum_next + SUM_W'(samples[i]);
        end
    end

    always_ff @(posedge aclk) begin
        wsum_reg <= wsum_next;
        sum_reg  <= sum_next;
    end

    assign wsum = wsum_reg;
    assign sum  = sum_reg;

endmodule

// File: hdl/lsc_divider.sv
// ----------------------------------------------------------------------------
// lsc_divider: restoring divider
// One quotient bit per cycle; the quotient is known to fit QUOT_W bits.
// ----------------------------------------------------------------------------
module lsc_divider #(
    parameter int SUM_W  = 13,
    parameter int QUOT_W = 13
) (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       start,
    input  logic [QUOT_W+SUM_W-1:0]    dividend,
    input  logic [SUM_W-1:0]           divisor,
    output logic [QUOT_W-1:0]          quotient,
    output lsc_pkg::lsc_div_status_t   status
);

    localparam int CNT_W = $clog2(QUOT_W + 1);

    logic [SUM_W-1:0]  rem_reg, rem_next;
    logic [QUOT_W-1:0] quot_reg, quot_next;
    logic [SUM_W-1:0]  dsr_reg, dsr_next;
    logic [CNT_W-1:0]  cnt_reg, cnt_next;
    logic              busy_reg, busy_next;
    logic [SUM_W:0]    trial;
    logic [SUM_W:0]    diff;
    logic              ge;

    assign trial = {rem_reg, quot_reg[QUOT_W-1]};
    assign diff  = trial - {1'b0, dsr_reg};
    assign ge    = (trial >= {1'b0, dsr_reg});

    always_comb begin
        rem_next  = rem_reg;
        quot_next = quot_reg;
        dsr_next  = dsr_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        if (start) begin
            // upper part is below the divisor since the quotient fits
            rem_next  = dividend[QUOT_W+SUM_W-1:QUOT_W];
            quot_next = dividend[QUOT_W-1:0];
            dsr_next  = divisor;
            cnt_next  = CNT_W'(QUOT_W);
            busy_next = 1'b1;
        end else if (busy_reg) begin
            rem_next  = ge ? diff[SUM_W-1:0] : trial[SUM_W-1:0];
            quot_next = {quot_reg[QUOT_W-2:0], ge};
            cnt_next  = cnt_reg - 1'b1;
            if (cnt_reg == CNT_W'(1)) begin
                busy_next = 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        rem_reg  <= rem_next;
        quot_reg <= quot_next;
        dsr_reg  <= dsr_next;
    end

    assign quotient            = quot_reg;
    assign status.busy         = busy_reg;
    assign status.zero_divisor = (dsr_reg == '0);

endmodule

// File: hdl/line_sensor_calibrate_and_centroid.sv
// ----------------------------------------------------------------------------
// line_sensor_calibrate_and_centroid: line sensor calibration and position
// Position item: decode, sum and start, then the 13-step restoring divider;
//   the result goes out when it is done; no new item is taken until then.
// Calibration step: no result. Final step: SENSORS threshold
//   items on consecutive cycles when the sink is ready.
// Reset (aresetn low, synchronous): min 1023, max 0, flag clear, limit 1000.
// ----------------------------------------------------------------------------
module line_sensor_calibrate_and_centroid #(
    parameter int SENSORS        = lsc_pkg::DEF_SENSORS,
    parameter int POSITION_SCALE = lsc_pkg::DEF_POSITION_SCALE
) (
    input  logic                             aclk,
    input  logic                             aresetn,
    // configuration: distance_limit
    input  logic                             cfg_wr_en,
    input  logic [lsc_pkg::TICK_W-1:0]       cfg_wr_data,
    // input items
    input  logic                             s_axis_tvalid,
    output logic                             s_axis_tready,
    // sample_0 .. sample_7 (10 each), left_ticks (16), right_ticks (16)
    input  logic [lsc_pkg::IN_DATA_W-1:0]    s_axis_tdata,
    // command
    input  logic                             s_axis_tuser,
    // result items
    output logic                             m_axis_tvalid,
    input  logic                             m_axis_tready,
    // sensor_index (3), value (13), low_seen (10), high_seen (10),
    // no_signal (1), calibrated (1), zero pad (2)
    output logic [lsc_pkg::OUT_DATA_W-1:0]   m_axis_tdata,
    // kind
    output logic                             m_axis_tuser,
    output logic                             m_axis_tlast
);

    localparam int SW      = lsc_pkg::SAMPLE_W;
    localparam int TW      = lsc_pkg::TICK_W;
    localparam int VW      = lsc_pkg::VALUE_W;
    localparam int IW      = lsc_pkg::IDX_W;
    localparam int NMAX    = lsc_pkg::MAX_SENSORS;
    localparam int WTERM_W = $clog2(lsc_pkg::SAMPLE_MAX * (SENSORS - 1) * POSITION_SCALE + 1);
    localparam int WSUM_W  =
        $clog2(lsc_pkg::SAMPLE_MAX * POSITION_SCALE * SENSORS * (SENSORS - 1) / 2 + 1);
    localparam int SUM_W   = $clog2(lsc_pkg::SAMPLE_MAX * SENSORS + 1);
    localparam int DIV_W   = VW + SUM_W;

    // ------------------------------------------------------------------
    // Configuration register
    // ------------------------------------------------------------------
    logic [TW-1:0] limit_reg, limit_next;

    assign limit_next = cfg_wr_en ? cfg_wr_data : limit_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            limit_reg <= lsc_pkg::LIMIT_RESET;
        end else begin
            limit_reg <= limit_next;
        end
    end

    // ------------------------------------------------------------------
    // Control state
    // ------------------------------------------------------------------
    lsc_pkg::lsc_state_t state_reg, state_next;
    logic [IW-1:0]       th_idx_reg, th_idx_next;
    logic                calib_reg, calib_next;
    logic                m_valid_reg, m_valid_next;

    // ------------------------------------------------------------------
    // Input item capture: hold the item for the whole computation
    // ------------------------------------------------------------------
    lsc_pkg::lsc_cmd_t           cmd_reg;
    logic [NMAX-1:0][SW-1:0]     sample_reg;
    logic [TW-1:0]               left_reg;
    logic [TW-1:0]               right_reg;
    logic                        in_accept;

    assign s_axis_tready = (state_reg == lsc_pkg::ST_IDLE);
    assign in_accept     = s_axis_tvalid && s_axis_tready;

    always_ff @(posedge aclk) begin
        if (in_accept) begin
            cmd_reg <= lsc_pkg::lsc_cmd_t'(s_axis_tuser);
            for (int i = 0; i < NMAX; i++) begin
                sample_reg[i] <= s_axis_tdata[i*SW +: SW];
            end
            left_reg  <= s_axis_tdata[NMAX*SW +: TW];
            right_reg <= s_axis_tdata[NMAX*SW+TW +: TW];
        end
    end

    // ------------------------------------------------------------------
    // Sensor lanes: one per active sensor, unused slots read as zero
    // ------------------------------------------------------------------
    logic                            lane_update;
    lsc_pkg::lsc_cal_t [NMAX-1:0]    lane_cal;
    logic [NMAX-1:0][WTERM_W-1:0]    lane_wterm;
    logic [NMAX-1:0][SW-1:0]         lane_sample;

    for (genvar g = 0; g < NMAX; g++) begin : g_lane
        if (g < SENSORS) begin : g_on
            lsc_lane #(
                .WEIGHT  (g * POSITION_SCALE),
                .WTERM_W (WTERM_W)
            ) u_lane (
                .aclk     (aclk),
                .aresetn  (aresetn),
                .sample   (sample_reg[g]),
                .update   (lane_update),
                .cal      (lane_cal[g]),
                .weighted (lane_wterm[g])
            );
            assign lane_sample[g] = sample_reg[g];
        end else begin : g_off
            // samples beyond the sensor count are ignored
            assign lane_cal[g]    = '0;
            assign lane_wterm[g]  = '0;
            assign lane_sample[g] = '0;
        end
    end

    // ------------------------------------------------------------------
    // Merge the lanes, then divide
    // ------------------------------------------------------------------
    logic [WSUM_W-1:0]          wsum;
    logic [SUM_W-1:0]           sum;
    logic                       div_start;
    logic [VW-1:0]              quotient;
    lsc_pkg::lsc_div_status_t   div_status;

    lsc_merge #(
        .WTERM_W (WTERM_W),
        .WSUM_W  (WSUM_W),
        .SUM_W   (SUM_W)
    ) u_merge (
        .aclk     (aclk),
        .weighted (lane_wterm),
        .samples  (lane_sample),
        .wsum     (wsum),
        .sum      (sum)
    );

    lsc_divider #(
        .SUM_W  (SUM_W),
        .QUOT_W (VW)
    ) u_divider (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (div_start),
        .dividend (DIV_W'(wsum)),
        .divisor  (sum),
        .quotient (quotient),
        .status   (div_status)
    );

    // ------------------------------------------------------------------
    // Output register: parts the result side from the work side
    // ------------------------------------------------------------------
    lsc_pkg::lsc_kind_t   out_kind_reg, out_kind_next;
    logic [IW-1:0]        out_idx_reg, out_idx_next;
    logic [VW-1:0]        out_value_reg, out_value_next;
    logic [SW-1:0]        out_low_reg, out_low_next;
    logic [SW-1:0]        out_high_reg, out_high_next;
    logic                 out_nosig_reg, out_nosig_next;
    logic                 out_calib_reg, out_calib_next;
    logic                 out_last_reg, out_last_next;
    logic                 out_free;
    logic                 limit_hit;
    logic                 th_last;
    lsc_pkg::lsc_cal_t    th_cal;

    assign out_free  = !m_valid_reg || m_axis_tready;
    assign limit_hit = (left_reg > limit_reg) || (right_reg > limit_reg);
    assign th_last   = (th_idx_reg == IW'(SENSORS - 1));
    assign th_cal    = lane_cal[th_idx_reg];

    always_comb begin
        state_next     = state_reg;
        th_idx_next    = th_idx_reg;
        calib_next     = calib_reg;
        lane_update    = 1'b0;
        div_start      = 1'b0;
        m_valid_next   = m_valid_reg && !m_axis_tready;
        out_kind_next  = out_kind_reg;
        out_idx_next   = out_idx_reg;
        out_value_next = out_value_reg;
        out_low_next   = out_low_reg;
        out_high_next  = out_high_reg;
        out_nosig_next = out_nosig_reg;
        out_calib_next = out_calib_reg;
        out_last_next  = out_last_reg;

        unique case (state_reg)
            lsc_pkg::ST_IDLE: begin
                if (in_accept) begin
                    state_next = lsc_pkg::ST_DECODE;
                end
            end
            lsc_pkg::ST_DECODE: begin
                // lanes register their weighted terms during this cycle
                if (cmd_reg == lsc_pkg::CMD_CALIBRATE) begin
                    if (limit_hit) begin
                        calib_next  = 1'b1;
                        th_idx_next = '0;
                        state_next  = lsc_pkg::ST_THRESH;
                    end else begin
                        lane_update = 1'b1;
                        state_next  = lsc_pkg::ST_IDLE;
                    end
                end else begin
                    state_next = lsc_pkg::ST_SUM;
                end
            end
            lsc_pkg::ST_SUM: begin
                state_next = lsc_pkg::ST_START;
            end
            lsc_pkg::ST_START: begin
                div_start  = 1'b1;
                state_next = lsc_pkg::ST_DIV;
            end
            lsc_pkg::ST_DIV: begin
                // hold until the quotient is done and the output slot frees up
                if (!div_status.busy && out_free) begin
                    m_valid_next   = 1'b1;
                    out_kind_next  = lsc_pkg::KIND_POSITION;
                    out_idx_next   = '0;
                    out_value_next = div_status.zero_divisor ? '0 : quotient;
                    out_low_next   = '0;
                    out_high_next  = '0;
                    out_nosig_next = div_status.zero_divisor;
                    out_calib_next = calib_reg;
                    out_last_next  = 1'b1;
                    state_next     = lsc_pkg::ST_IDLE;
                end
            end
            lsc_pkg::ST_THRESH: begin
                // one threshold item per sensor, in sensor order
                if (out_free) begin
                    m_valid_next   = 1'b1;
                    out_kind_next  = lsc_pkg::KIND_THRESHOLD;
                    out_idx_next   = th_idx_reg;
                    out_value_next = VW'(th_cal.threshold);
                    out_low_next   = th_cal.low;
                    out_high_next  = th_cal.high;
                    out_nosig_next = 1'b0;
                    out_calib_next = calib_reg;
                    out_last_next  = th_last;
                    th_idx_next    = th_idx_reg + 1'b1;
                    if (th_last) begin
                        state_next = lsc_pkg::ST_IDLE;
                    end
                end
            end
            default: begin
                state_next = lsc_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= lsc_pkg::ST_IDLE;
            th_idx_reg  <= '0;
            calib_reg   <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            th_idx_reg  <= th_idx_next;
            calib_reg   <= calib_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        out_kind_reg  <= out_kind_next;
        out_idx_reg   <= out_idx_next;
        out_value_reg <= out_value_next;
        out_low_reg   <= out_low_next;
        out_high_reg  <= out_high_next;
        out_nosig_reg <= out_nosig_next;
        out_calib_reg <= out_calib_next;
        out_last_reg  <= out_last_next;
    end

    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tuser  = out_kind_reg;
    assign m_axis_tlast  = out_last_reg;
    assign m_axis_tdata  = {2'b00, out_calib_reg, out_nosig_reg, out_high_reg,
                            out_low_reg, out_value_reg, out_idx_reg};

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    // the divider only runs while the controller waits on it
    assert property (@(posedge aclk) disable iff (!aresetn)
        div_status.busy |-> (state_reg == lsc_pkg::ST_DIV))
        else $error("divider busy outside the divide state");

    // a position item always closes its run
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && (out_kind_reg == lsc_pkg::KIND_POSITION)) |-> out_last_reg)
        else $error("position item without last");

    // threshold items only come after the flag is set, and name a real sensor
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && (out_kind_reg == lsc_pkg::KIND_THRESHOLD))
            |-> (out_calib_reg && ({1'b0, out_idx_reg} < (IW + 1)'(SENSORS))))
        else $error("threshold item with bad flag or sensor index");

    // an accepted item moves the controller to the decode state
    assert property (@(posedge aclk) disable iff (!aresetn)
        in_accept |=> (state_reg == lsc_pkg::ST_DECODE))
        else $error("accepted item not decoded");

endmodule
